FILE: hdl/rcc_pkg.sv
// Shared types, codes and constants of the roaring container checker.
`timescale 1ns / 1ps
package rcc_pkg;

  localparam int DATA_W = 16;
  localparam int CNT_W = 12;
  localparam int OFFS_W = 8;
  localparam int WIDX_W = 13;
  localparam int END_W = DATA_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam int CONT_SPAN = 2048;
  localparam int NUM_SEGS = 8;
  localparam int ARRAY_THRESHOLD = 8;
  localparam int RUN_THRESHOLD = 4;
  localparam int MAX_ARRAY_ENTRIES = 248;
  localparam int MAX_RUNS = 124;
  localparam int SIZE_RESET = 2048;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_COUNT  = 3'd1,
    ST_NO_SEG = 3'd2,
    ST_ORDER  = 3'd3,
    ST_RUN    = 3'd4,
    ST_CARD   = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KIND    = 2'd0,
    CFG_ENTRIES = 2'd1,
    CFG_SIZE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_WORK,
    S_FETCH,
    S_SCAN,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              is_run;
    logic              nz;
    logic              last;
    logic [END_W-1:0]  value;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] pending;
    logic [CNT_W-1:0]  csize;
  } chk_req_t;

  typedef struct packed {
    logic              emit;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] run_end;
    status_t           status;
    logic              last;
  } chk_res_t;

endpackage

FILE: hdl/rcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rcc_check.sv
// Order, range and overlap check of one decoded array value or run.
`timescale 1ns / 1ps
module rcc_check (
  input  rcc_pkg::chk_req_t req,
  output rcc_pkg::chk_res_t res
);
  import rcc_pkg::*;

  logic [DATA_W-1:0] v;
  logic [END_W-1:0]  lim;
  logic              terminal;
  logic              bad;

  always_comb begin
    v = req.value[DATA_W-1:0];
    lim = {{(END_W-CNT_W){1'b0}}, req.csize};
    terminal = 1'b0;
    bad = 1'b0;
    res.emit = 1'b1;
    if (!req.is_run) begin
      bad = (req.nz && (v <= req.prev)) || ({{(DATA_W-CNT_W){1'b0}}, req.csize} <= v);
      res.first = v;
      res.run_end = '0;
      res.status = bad ? ST_ORDER : ST_OK;
      res.last = bad | req.last;
    end else begin
      // the final run may end one past the container
      terminal = req.last && (req.value == lim + END_W'(1));
      bad = (req.nz && (req.pending < req.prev)) ||
            (req.value <= {1'b0, req.pending}) ||
            ((req.value > lim) && !terminal);
      res.first = req.pending;
      res.run_end = req.value[DATA_W-1:0];
      res.status = bad ? ST_RUN : ST_OK;
      res.last = bad | req.last;
    end
  end

endmodule

FILE: hdl/roaring_container_checker.sv
// Top level: sequencer that decodes and checks array and run container words.
// S_WORK decodes an accepted word and loads a plain word's result; a start word passes
// S_CLEAR first. A compressed offset word goes on to S_FETCH, S_SCAN and S_CHECK,
// repeating S_FETCH and S_SCAN per empty segment skipped, as the count store is read one
// entry per fetch through a registered read port. Only S_IDLE takes a new word; a result
// waits in the output register, and one that finds it full holds the sequencer. Reset
// (rst_n low, synchronous) closes the container, empties the output; counts are kept.
`timescale 1ns / 1ps
module roaring_container_checker #(
  parameter int NUM_SEGS = rcc_pkg::NUM_SEGS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcc_pkg::CNT_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rcc_pkg::DATA_W-1:0]     in_element,
  input  logic                           in_container_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rcc_pkg::DATA_W-1:0]     out_first_value,
  output logic [rcc_pkg::DATA_W-1:0]     out_run_end,
  output logic [2:0]                     out_status,
  output logic                           out_last_of_container
);
  import rcc_pkg::*;

  localparam int AW = $clog2(NUM_SEGS);
  localparam int CW = $clog2(NUM_SEGS + 1);
  localparam int SEG_SIZE = CONT_SPAN / NUM_SEGS;

  // configuration
  logic              kind_r;
  logic [CNT_W-1:0]  entries_r;
  logic [CNT_W-1:0]  csize_r;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] elem_r, elem_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [OFFS_W-1:0] taken_r, taken_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic [DATA_W-1:0] pending_r, pending_nxt;
  logic              closed_r, closed_nxt;
  logic [DATA_W-1:0] base_r, base_nxt;
  logic [END_W-1:0]  val_r, val_nxt;
  logic              odd_r, odd_nxt;
  logic              nz_r, nz_nxt;
  logic              last_r, last_nxt;
  chk_res_t          res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  chk_res_t          out_r, out_nxt;
  logic              load_out;

  // count store
  logic              ram_we;
  logic [OFFS_W-1:0] ram_rdata;

  // combinational helpers
  logic              compressed;
  logic              card_bad;
  logic [WIDX_W-1:0] d_c;
  logic              odd_c, nz_c, last_c;
  logic [END_W-1:0]  value_c;
  logic [WIDX_W-1:0] sum_wide;
  logic [CNT_W-1:0]  sum_sat;
  logic              sum_ok;
  logic              skip;
  logic [DATA_W-1:0] add_out;
  logic              slot_free;
  chk_req_t          chk_req;
  chk_res_t          chk_res;
  chk_res_t          emit_c;

  rcc_ram #(
    .WIDTH (OFFS_W),
    .DEPTH (NUM_SEGS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r[AW-1:0]),
    .wdata (elem_r[OFFS_W-1:0]),
    .raddr (cursor_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  rcc_check u_check (
    .req (chk_req),
    .res (chk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= 1'b0;
      entries_r <= '0;
      csize_r <= CNT_W'(SIZE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KIND:    kind_r <= cfg_wdata[0];
        CFG_ENTRIES: entries_r <= cfg_wdata;
        CFG_SIZE:    csize_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      cursor_r <= '0;
      taken_r <= '0;
      sum_r <= '0;
      prev_r <= '0;
      pending_r <= '0;
      closed_r <= 1'b1;
      base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      widx_r <= widx_nxt;
      cursor_r <= cursor_nxt;
      taken_r <= taken_nxt;
      sum_r <= sum_nxt;
      prev_r <= prev_nxt;
      pending_r <= pending_nxt;
      closed_r <= closed_nxt;
      base_r <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    val_r <= val_nxt;
    odd_r <= odd_nxt;
    nz_r <= nz_nxt;
    last_r <= last_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // decode of the current word position and count checks
  always_comb begin
    compressed = kind_r ? (entries_r >= CNT_W'(RUN_THRESHOLD))
                        : (entries_r >= CNT_W'(ARRAY_THRESHOLD));
    card_bad = kind_r ? ((entries_r == '0) || (entries_r >= CNT_W'(MAX_RUNS)))
                      : (entries_r > CNT_W'(MAX_ARRAY_ENTRIES));
    d_c = widx_r - (compressed ? WIDX_W'(NUM_SEGS) : '0);
    odd_c = d_c[0];
    if (kind_r) begin
      nz_c = (d_c[WIDX_W-1:1] != '0);
      last_c = ({1'b0, d_c[WIDX_W-1:1]} + WIDX_W'(1)) == {1'b0, entries_r};
    end else begin
      nz_c = (d_c != '0);
      last_c = ({1'b0, d_c} + (WIDX_W+1)'(1)) == {2'b0, entries_r};
    end
    if (!kind_r) begin
      value_c = {1'b0, elem_r};
    end else begin
      value_c = {1'b0, pending_r} + END_W'(1) + {1'b0, elem_r};
    end
    sum_wide = {1'b0, sum_r} + WIDX_W'(elem_r[OFFS_W-1:0]);
    sum_sat = sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];
    sum_ok = kind_r ? (({1'b0, sum_sat} == {entries_r, 1'b0}) ||
                       (({1'b0, sum_sat} + WIDX_W'(1)) == {entries_r, 1'b0}))
                    : (sum_sat == entries_r);
    // shared segment adder: advance the base or add the offset
    skip = (taken_r >= ram_rdata);
    add_out = base_r + (skip ? DATA_W'(SEG_SIZE) : {{(DATA_W-OFFS_W){1'b0}},
                                                   elem_r[OFFS_W-1:0]});
    slot_free = !out_valid_r || out_ready;

    chk_req.is_run = kind_r;
    chk_req.prev = prev_r;
    chk_req.pending = pending_r;
    chk_req.csize = csize_r;
    if (state_r == S_WORK) begin
      chk_req.nz = nz_c;
      chk_req.last = last_c;
      chk_req.value = value_c;
    end else begin
      chk_req.nz = nz_r;
      chk_req.last = last_r;
      chk_req.value = val_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    elem_nxt = elem_r;
    widx_nxt = widx_r;
    cursor_nxt = cursor_r;
    taken_nxt = taken_r;
    sum_nxt = sum_r;
    prev_nxt = prev_r;
    pending_nxt = pending_r;
    closed_nxt = closed_r;
    base_nxt = base_r;
    val_nxt = val_r;
    odd_nxt = odd_r;
    nz_nxt = nz_r;
    last_nxt = last_r;
    res_nxt = res_r;
    out_nxt = out_r;
    load_out = 1'b0;
    ram_we = 1'b0;
    in_ready = (state_r == S_IDLE);
    emit_c.emit = 1'b0;
    emit_c.first = '0;
    emit_c.run_end = '0;
    emit_c.status = ST_OK;
    emit_c.last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          elem_nxt = in_element;
          state_nxt = in_container_start ? S_CLEAR : S_WORK;
        end
      end
      S_CLEAR: begin
        widx_nxt = '0;
        cursor_nxt = '0;
        taken_nxt = '0;
        sum_nxt = '0;
        prev_nxt = '0;
        pending_nxt = '0;
        base_nxt = '0;
        closed_nxt = 1'b0;
        state_nxt = S_WORK;
        if (card_bad) begin
          emit_c.emit = 1'b1;
          emit_c.status = ST_CARD;
        end else if (!kind_r && (entries_r == '0)) begin
          // empty array: drop the item and close
          closed_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WORK: begin
        state_nxt = S_IDLE;
        if (closed_r) begin
          state_nxt = S_IDLE;
        end else if (compressed && (widx_r < WIDX_W'(NUM_SEGS))) begin
          ram_we = 1'b1;
          sum_nxt = sum_sat;
          widx_nxt = widx_r + WIDX_W'(1);
          if ((widx_r + WIDX_W'(1) == WIDX_W'(NUM_SEGS)) && !sum_ok) begin
            emit_c.emit = 1'b1;
            emit_c.status = ST_COUNT;
          end
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
          odd_nxt = odd_c;
          nz_nxt = nz_c;
          last_nxt = last_c;
          if (compressed) begin
            state_nxt = S_FETCH;
          end else if (kind_r && !odd_c) begin
            pending_nxt = elem_r;
          end else begin
            emit_c = chk_res;
            if (chk_res.status == ST_OK) begin
              prev_nxt = kind_r ? chk_res.run_end : chk_res.first;
            end
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cursor_r == CW'(NUM_SEGS)) begin
          if (kind_r && odd_r && last_r && (elem_r[OFFS_W-1:0] == '0)) begin
            val_nxt = {1'b0, base_r};
            state_nxt = S_CHECK;
          end else begin
            emit_c.emit = 1'b1;
            emit_c.status = ST_NO_SEG;
          end
        end else if (skip) begin
          // empty or used-up segment: advance and read the next count
          taken_nxt = '0;
          cursor_nxt = cursor_r + CW'(1);
          base_nxt = add_out;
          state_nxt = S_FETCH;
        end else begin
          val_nxt = {1'b0, add_out};
          taken_nxt = taken_r + OFFS_W'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
        if (kind_r && !odd_r) begin
          pending_nxt = val_r[DATA_W-1:0];
        end else begin
          emit_c = chk_res;
          if (chk_res.status == ST_OK) begin
            prev_nxt = kind_r ? chk_res.run_end : chk_res.first;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          out_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hand the result to the output register, or hold it until the slot frees
    if (emit_c.emit) begin
      if (emit_c.last) begin
        closed_nxt = 1'b1;
      end
      if (slot_free) begin
        load_out = 1'b1;
        out_nxt = emit_c;
        state_nxt = S_IDLE;
      end else begin
        res_nxt = emit_c;
        state_nxt = S_EMIT;
      end
    end

    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;
  assign out_first_value = out_r.first;
  assign out_run_end = out_r.run_end;
  assign out_status = out_r.status;
  assign out_last_of_container = out_r.last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer took an item without leaving idle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cursor_r <= CW'(NUM_SEGS)))
    else $error("segment cursor ran past the last segment");

  a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_nxt.last) |=> closed_r)
    else $error("container left open after a final or error result");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_last_of_container)
    else $error("error result not marked as last of container");

endmodule

FILE: sim/testbench.sv
// Self-checking bench for the roaring container checker: random container words vs a predictor.
`timescale 1ns / 1ps
module testbench;
  import rcc_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 9;
  localparam int SEG_SIZE = CONT_SPAN / NUM_SEGS;
  localparam int SETTLE_CYCLES = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 950;
  localparam int CALM_WORDS = 150;

  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic              start;
  } word_t;

  typedef struct packed {
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] rend;
    status_t           st;
    logic              last;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic [DATA_W-1:0]    in_element = '0;
  logic                 in_container_start = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_first_value;
  logic [DATA_W-1:0]    out_run_end;
  logic [2:0]           out_status;
  logic                 out_last_of_container;

  roaring_container_checker DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_element            (in_element),
    .in_container_start    (in_container_start),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_first_value       (out_first_value),
    .out_run_end           (out_run_end),
    .out_status            (out_status),
    .out_last_of_container (out_last_of_container)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies and container state of the predictor
  logic             cfg_run = 1'b0;
  logic [CNT_W-1:0] cfg_entries = '0;
  logic [CNT_W-1:0] cfg_size = CNT_W'(SIZE_RESET);

  logic [OFFS_W-1:0] seg_fill [NUM_SEGS];
  int unsigned       word_pos = 0;
  int unsigned       seg_cur = 0;
  int unsigned       seg_taken = 0;
  int unsigned       count_total = 0;
  logic [DATA_W-1:0] last_pos = '0;
  logic [DATA_W-1:0] run_open = '0;
  bit                closed = 1'b1;

  word_t   words_to_send [$];
  result_t results_due [$];
  int      words_pushed = 0;
  int      words_taken = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      calm_from = 32'h7fffffff;
  bit      idling = 1'b1;
  int      send_gap = 0;
  int      hold_ready = 0;
  word_t   next_word;
  result_t want;

  function automatic void add_result(input logic [DATA_W-1:0] f, input logic [DATA_W-1:0] r,
                                     input status_t st, input logic last);
    result_t res;
    res.first = f;
    res.rend = r;
    res.st = st;
    res.last = last;
    results_due.insert(results_due.size(), res);
    if (last) closed = 1'b1;
  endfunction

  // Take the next segment position; when the segments run out, fail unless the end is allowed.
  function automatic bit next_position(input logic [OFFS_W-1:0] offs, input bit allow_end,
                                       output logic [DATA_W-1:0] pos);
    pos = '0;
    while (seg_cur < NUM_SEGS && seg_taken >= seg_fill[seg_cur]) begin
      seg_taken = 0;
      seg_cur++;
    end
    if (seg_cur >= NUM_SEGS) begin
      if (!allow_end || offs != 0) return 1'b0;
      pos = DATA_W'(NUM_SEGS * SEG_SIZE);
      return 1'b1;
    end
    pos = DATA_W'(seg_cur * SEG_SIZE + offs);
    seg_taken++;
    return 1'b1;
  endfunction

  function automatic void decode_word(input logic [DATA_W-1:0] e, input logic start);
    int unsigned       n;
    int unsigned       d;
    int unsigned       r;
    int unsigned       stop;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] s;
    bit                comp;
    bit                fin;
    bit                ok;
    bit                terminal;
    n = cfg_entries;
    comp = cfg_run ? (n >= RUN_THRESHOLD) : (n >= ARRAY_THRESHOLD);
    if (start) begin
      word_pos = 0;
      seg_cur = 0;
      seg_taken = 0;
      count_total = 0;
      last_pos = '0;
      run_open = '0;
      closed = 1'b0;
      if (cfg_run ? (n == 0 || n >= MAX_RUNS) : (n > MAX_ARRAY_ENTRIES)) begin
        add_result('0, '0, ST_CARD, 1'b1);
        return;
      end
      if (!cfg_run && n == 0) begin
        closed = 1'b1;
        return;
      end
    end
    if (closed) return;

    if (comp && word_pos < NUM_SEGS) begin
      seg_fill[word_pos] = e[OFFS_W-1:0];
      count_total += e[OFFS_W-1:0];
      if (count_total > 4095) count_total = 4095;
      word_pos++;
      if (word_pos == NUM_SEGS) begin
        ok = cfg_run ? (count_total == 2 * n || count_total + 1 == 2 * n) : (count_total == n);
        if (!ok) add_result('0, '0, ST_COUNT, 1'b1);
      end
      return;
    end

    d = word_pos - (comp ? NUM_SEGS : 0);
    word_pos = (word_pos + 1) & 32'h1fff;

    if (!cfg_run) begin
      fin = (d + 1 == n);
      if (comp) begin
        if (!next_position(e[OFFS_W-1:0], 1'b0, v)) begin
          add_result('0, '0, ST_NO_SEG, 1'b1);
          return;
        end
      end else begin
        v = e;
      end
      if ((d > 0 && v <= last_pos) || v >= cfg_size) begin
        add_result(v, '0, ST_ORDER, 1'b1);
        return;
      end
      last_pos = v;
      add_result(v, '0, ST_OK, fin);
    end else begin
      r = d >> 1;
      fin = (r + 1 == n);
      if (d[0] == 1'b0) begin
        if (comp) begin
          if (!next_position(e[OFFS_W-1:0], 1'b0, v)) begin
            add_result('0, '0, ST_NO_SEG, 1'b1);
            return;
          end
        end else begin
          v = e;
        end
        run_open = v;
        return;
      end
      s = run_open;
      if (comp) begin
        if (!next_position(e[OFFS_W-1:0], fin, v)) begin
          add_result('0, '0, ST_NO_SEG, 1'b1);
          return;
        end
        stop = v;
      end else begin
        stop = s + 1 + e;
      end
      // the final run may close one past the container
      terminal = fin && stop == cfg_size + 1;
      if ((r > 0 && s < last_pos) || stop <= s || (stop > cfg_size && !terminal)) begin
        add_result(s, DATA_W'(stop), ST_RUN, 1'b1);
        return;
      end
      last_pos = DATA_W'(stop);
      add_result(s, DATA_W'(stop), ST_OK, fin);
    end
  endfunction

  // Input driver: hold each item until taken, with random gaps between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word(in_element, in_container_start);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          next_word = words_to_send.pop_front();
          in_valid <= 1'b1;
          in_element <= next_word.elem;
          in_container_start <= next_word.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expected result, stall ready in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result first=%h end=%h status=%0d last=%b", $time,
                   out_first_value, out_run_end, out_status, out_last_of_container);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_first_value !== want.first || out_run_end !== want.rend ||
              out_status !== want.st || out_last_of_container !== want.last) begin
            $display("%0t: result mismatch: expected first=%h end=%h status=%0d last=%b",
                     $time, want.first, want.rend, want.st, want.last);
            $display("%0t:                    actual first=%h end=%h status=%0d last=%b",
                     $time, out_first_value, out_run_end, out_status, out_last_of_container);
            mismatches++;
          end
        end
      end
      if (hold_ready != 0) begin
        hold_ready <= hold_ready - 1;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        hold_ready <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_word(input logic [DATA_W-1:0] e, input logic s);
    word_t w;
    w.elem = e;
    w.start = s;
    words_to_send.insert(words_to_send.size(), w);
    words_pushed++;
  endtask

  // Wait until every item is taken and every result is in, then let the block drain.
  task automatic settle();
    while (words_taken != words_pushed || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KIND:    cfg_run = val[0];
      CFG_ENTRIES: cfg_entries = val[CNT_W-1:0];
      CFG_SIZE:    cfg_size = val[CNT_W-1:0];
      default:     ;
    endcase
  endtask

  task automatic start_phase(input bit run, input int n, input int size);
    settle();
    idling <= (words_pushed < calm_from) && ($urandom_range(0, 3) != 0);
    write_reg(CFG_KIND, run);
    write_reg(CFG_ENTRIES, n);
    write_reg(CFG_SIZE, size);
  endtask

  function automatic int spread(input int span, input int left);
    int c;
    c = span / left * 2 + 1;
    return (c > span) ? span : c;
  endfunction

  // Build one well-formed container with random content, then maybe break it.
  task automatic send_container(input bit run, input int n, input int size);
    int    pos [$];
    word_t words [$];
    word_t w;
    int    fill [NUM_SEGS];
    int    lo;
    int    hi;
    int    a;
    int    b;
    int    lim;
    int    k;
    int    keep;
    int    mode;
    bit    comp;
    comp = run ? (n >= RUN_THRESHOLD) : (n >= ARRAY_THRESHOLD);
    lim = (run && comp && size > CONT_SPAN - 1) ? CONT_SPAN - 1 : size;
    lo = 0;
    for (k = 0; k < n; k++) begin
      if (!run) begin
        hi = size - (n - k);
        a = lo + $urandom_range(0, spread(hi - lo, n - k));
        pos.insert(pos.size(), a);
        lo = a + 1;
      end else begin
        hi = lim - (n - k);
        a = lo + $urandom_range(0, spread(hi - lo, n - k));
        hi = lim - (n - k - 1);
        b = a + 1 + $urandom_range(0, spread(hi - a - 1, n - k));
        pos.insert(pos.size(), a);
        pos.insert(pos.size(), b);
        lo = b;
      end
    end
    // stretch the final run to the container end or one past it
    if (run && $urandom_range(0, 3) == 0)
      pos[pos.size() - 1] = (comp && size >= CONT_SPAN - 1) ? CONT_SPAN : size + 1;

    w.start = 1'b0;
    if (comp) begin
      foreach (fill[s]) fill[s] = 0;
      foreach (pos[j]) if (pos[j] < CONT_SPAN) fill[pos[j] / SEG_SIZE]++;
      foreach (fill[s]) begin
        w.elem = {8'($urandom), 8'(fill[s])};
        words.insert(words.size(), w);
      end
      foreach (pos[j]) begin
        w.elem = {8'($urandom), 8'(pos[j] % SEG_SIZE)};
        words.insert(words.size(), w);
      end
    end else if (!run) begin
      foreach (pos[j]) begin
        w.elem = DATA_W'(pos[j]);
        words.insert(words.size(), w);
      end
    end else begin
      for (k = 0; k < n; k++) begin
        w.elem = DATA_W'(pos[2 * k]);
        words.insert(words.size(), w);
        w.elem = DATA_W'(pos[2 * k + 1] - pos[2 * k] - 1);
        words.insert(words.size(), w);
      end
    end
    w = words[0];
    w.start = 1'b1;
    words[0] = w;

    // cut big containers short
    if (n > 40) begin
      keep = $urandom_range(1, 12);
      while (words.size() > keep) void'(words.pop_back());
    end

    if ($urandom_range(0, 9) < 3) begin
      mode = $urandom_range(0, 3);
      if (mode == 3) begin
        keep = $urandom_range(1, words.size());
        while (words.size() > keep) void'(words.pop_back());
      end else begin
        if (mode == 1 && comp && words.size() >= NUM_SEGS)
          k = $urandom_range(0, NUM_SEGS - 1);
        else
          k = $urandom_range(0, words.size() - 1);
        w = words[k];
        case (mode)
          0:       w.elem = DATA_W'($urandom);
          1:       w.elem[7:0] = w.elem[7:0] + (($urandom_range(0, 1) != 0) ? 8'd1 : 8'hff);
          default: w.start = 1'b1;
        endcase
        words[k] = w;
      end
    end

    foreach (words[j]) push_word(words[j].elem, words[j].start);
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) push_word(DATA_W'($urandom), 1'b0);
  endtask

  initial begin
    bit run;
    int n;
    int size;
    int goal;
    bit card_bad;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // bad cardinalities; closed container ignores plain words
    start_phase(1'b1, 0, CONT_SPAN);
    push_word(16'h1234, 1'b1);
    push_word(16'habcd, 1'b0);
    start_phase(1'b1, MAX_RUNS, CONT_SPAN);
    push_word(16'h0000, 1'b1);
    start_phase(1'b0, MAX_ARRAY_ENTRIES + 1, CONT_SPAN);
    push_word(16'hffff, 1'b1);
    // empty array: start word dropped, no result
    start_phase(1'b0, 0, 1);
    push_word(16'hffff, 1'b1);
    push_word(16'h0000, 1'b0);
    start_phase(1'b0, 1, 1);
    push_word(16'h0000, 1'b1);
    // array order and range faults
    start_phase(1'b0, 3, CONT_SPAN);
    push_word(16'd5, 1'b1);
    push_word(16'd5, 1'b0);
    start_phase(1'b0, 2, CONT_SPAN);
    push_word(16'hffff, 1'b1);
    // count words sum short of the cardinality
    start_phase(1'b0, ARRAY_THRESHOLD, CONT_SPAN);
    push_word(16'hff00, 1'b1);
    repeat (NUM_SEGS - 1) push_word(16'h5500, 1'b0);
    // final run ends one past the container
    start_phase(1'b1, 1, CONT_SPAN);
    push_word(16'd2000, 1'b1);
    push_word(16'd48, 1'b0);
    // second run starts before the end of the first
    start_phase(1'b1, 2, CONT_SPAN);
    push_word(16'd100, 1'b1);
    push_word(16'd9, 1'b0);
    push_word(16'd50, 1'b0);
    push_word(16'hffff, 1'b0);

    goal = words_pushed + RANDOM_WORDS;
    calm_from = goal - CALM_WORDS;
    while (words_pushed < goal) begin
      run = $urandom_range(0, 1);
      if ($urandom_range(0, 19) == 0) begin
        if (run) begin
          case ($urandom_range(0, 6))
            0: n = 0;
            1: n = 1;
            2: n = RUN_THRESHOLD - 1;
            3: n = RUN_THRESHOLD;
            4: n = MAX_RUNS - 1;
            5: n = MAX_RUNS;
            default: n = CONT_SPAN;
          endcase
        end else begin
          case ($urandom_range(0, 7))
            0: n = 0;
            1: n = 1;
            2: n = ARRAY_THRESHOLD - 1;
            3: n = ARRAY_THRESHOLD;
            4: n = MAX_ARRAY_ENTRIES - 1;
            5: n = MAX_ARRAY_ENTRIES;
            6: n = MAX_ARRAY_ENTRIES + 1;
            default: n = CONT_SPAN;
          endcase
        end
      end else if (run) begin
        n = ($urandom_range(0, 9) < 6) ? $urandom_range(1, RUN_THRESHOLD - 1)
                                       : $urandom_range(RUN_THRESHOLD, 20);
      end else begin
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, ARRAY_THRESHOLD - 1)
                                       : $urandom_range(ARRAY_THRESHOLD, 40);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: size = CONT_SPAN;
        3:       size = 1;
        4:       size = CONT_SPAN - 1;
        default: size = $urandom_range(1, CONT_SPAN);
      endcase
      card_bad = run ? (n == 0 || n >= MAX_RUNS) : (n > MAX_ARRAY_ENTRIES);
      if (!card_bad && size < n) size = n;
      start_phase(run, n, size);
      if (card_bad || n == 0) begin
        push_word(DATA_W'($urandom), 1'b1);
        if ($urandom_range(0, 1) != 0) push_word(DATA_W'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) send_container(run, n, size);
      end
    end

    settle();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
